// File: hdl/saq_pkg.sv
// ============================================================================
// saq_pkg
// Shared constants, codes and request/response types of the sorted alarm queue.
// ============================================================================
`default_nettype none

package saq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_FIRED = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  alarm_id;
        logic [31:0] alarm_time;
        logic [31:0] current_time;
    } t_in_req;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [3:0]  fired_id;
        logic        last;
        logic        armed;
        logic [31:0] next_alarm_time;
    } t_out_rsp;

    typedef struct packed {
        logic [31:0] alarm_time;
        logic [3:0]  alarm_id;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_SCAN      = 7'b0000010,
        ST_REMOVE    = 7'b0000100,
        ST_INSERT    = 7'b0001000,
        ST_EXP_CHECK = 7'b0010000,
        ST_EXP_POP   = 7'b0100000,
        ST_RESP      = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

// File: hdl/saq_ram.sv
// ============================================================================
// saq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module saq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: hdl/sorted_alarm_queue_top.sv
// ============================================================================
// sorted_alarm_queue_top
// Pending alarms kept sorted by expiry time in a slot RAM used as a ring.
//
//   channel   signals                          payload
//   request   i_in_valid / o_in_stall          i_in_req  (saq_pkg::t_in_req)
//   response  o_out_valid / i_out_stall        o_out_rsp (saq_pkg::t_out_rsp)
//
// Add/cancel: id scan, removal shift and insertion shift, one slot per cycle
// through the single read and write port of the slot RAM. Expire: each fired
// alarm is a head pop (a ring pointer advance plus one read of the new head);
// with nothing due only an ack is sent.
// Reset clears state, count, ring base and valid flags only; slot contents need no clearing pass.
// A stalled response holds the engine; the next request is taken at once.
// ============================================================================
`default_nettype none

module sorted_alarm_queue_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire saq_pkg::t_in_req   i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output saq_pkg::t_out_rsp       o_out_rsp
);

    localparam int AW    = saq_pkg::AW;
    localparam int CW    = saq_pkg::CW;
    localparam int NW    = saq_pkg::NW;
    localparam int Depth = saq_pkg::QUEUE_DEPTH;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [CW-1:0] lidx);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(lidx);
        if (s >= (CW+1)'(Depth)) begin
            s = s - (CW+1)'(Depth);
        end
        return s[AW-1:0];
    endfunction

    saq_pkg::t_state   r_state, n_state;
    saq_pkg::t_in_req  r_req, n_req;
    saq_pkg::t_slot    r_head, n_head;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_base, n_base;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic              r_dv, n_dv;
    logic [AW-1:0]     r_didx, n_didx;
    logic [1:0]        r_status, n_status;
    logic [NW-1:0]     r_n, n_n;
    logic              r_out_valid;
    saq_pkg::t_out_rsp r_out;

    logic              rd_en;
    logic [CW-1:0]     rd_lidx;
    logic              wr_en;
    logic [CW-1:0]     wr_lidx;
    saq_pkg::t_slot    wr_data;
    logic [saq_pkg::SLOT_W-1:0] ram_rd_data;
    saq_pkg::t_slot    rd_slot;
    saq_pkg::t_slot    new_slot;
    saq_pkg::t_out_rsp out_data;
    logic              out_load;
    logic              out_free;
    logic              accept;
    logic [CW-1:0]     cnt_dec;
    logic [CW-1:0]     ptr_dec;
    logic              more;
    logic              nxt_due;

    saq_ram #(
        .WIDTH(saq_pkg::SLOT_W),
        .DEPTH(Depth)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (f_phys(r_base, wr_lidx)),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (f_phys(r_base, rd_lidx)),
        .o_rd_data (ram_rd_data)
    );

    assign rd_slot    = saq_pkg::t_slot'(ram_rd_data);
    assign new_slot   = '{alarm_time: r_req.alarm_time, alarm_id: r_req.alarm_id};
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != saq_pkg::ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign cnt_dec    = r_cnt - CW'(1);
    assign ptr_dec    = r_ptr - CW'(1);
    assign more       = (r_cnt > CW'(1));
    assign nxt_due    = more && (rd_slot.alarm_time <= r_req.current_time)
                        && ((r_n + NW'(1)) < NW'(saq_pkg::MAX_RESULTS));

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_head   = r_head;
        n_cnt    = r_cnt;
        n_base   = r_base;
        n_ptr    = r_ptr;
        n_dv     = 1'b0;
        n_didx   = r_didx;
        n_status = r_status;
        n_n      = r_n;
        rd_en    = 1'b0;
        rd_lidx  = r_ptr;
        wr_en    = 1'b0;
        wr_lidx  = '0;
        wr_data  = rd_slot;
        out_load = 1'b0;
        out_data = '0;

        unique case (r_state)
            saq_pkg::ST_IDLE: begin
                if (accept) begin
                    n_req    = i_in_req;
                    n_status = saq_pkg::STATUS_OK;
                    n_n      = '0;
                    case (i_in_req.op) inside
                        saq_pkg::OP_ADD, saq_pkg::OP_CANCEL: begin
                            n_ptr = '0;
                            if (r_cnt != '0) begin
                                n_state = saq_pkg::ST_SCAN;
                            end else if (i_in_req.op == saq_pkg::OP_CANCEL) begin
                                n_status = saq_pkg::STATUS_NOT_FOUND;
                                n_state  = saq_pkg::ST_RESP;
                            end else begin
                                n_state = saq_pkg::ST_INSERT;
                            end
                        end
                        saq_pkg::OP_EXPIRE: begin
                            n_state = saq_pkg::ST_EXP_CHECK;
                        end
                        default: begin
                            n_state = saq_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            saq_pkg::ST_SCAN: begin
                if (r_ptr < r_cnt) begin
                    rd_en  = 1'b1;
                    n_ptr  = r_ptr + CW'(1);
                    n_dv   = 1'b1;
                    n_didx = r_ptr[AW-1:0];
                end
                if (r_dv) begin
                    if (rd_slot.alarm_id == r_req.alarm_id) begin
                        n_state = saq_pkg::ST_REMOVE;
                        n_dv    = 1'b0;
                        n_ptr   = CW'(r_didx) + CW'(1);
                    end else if (CW'(r_didx) == cnt_dec) begin
                        n_dv = 1'b0;
                        if (r_req.op == saq_pkg::OP_CANCEL) begin
                            n_status = saq_pkg::STATUS_NOT_FOUND;
                            n_state  = saq_pkg::ST_RESP;
                        end else if (r_cnt == CW'(Depth)) begin
                            n_status = saq_pkg::STATUS_FULL;
                            n_state  = saq_pkg::ST_RESP;
                        end else begin
                            n_ptr   = r_cnt;
                            n_state = saq_pkg::ST_INSERT;
                        end
                    end
                end
            end

            saq_pkg::ST_REMOVE: begin
                if (r_ptr < r_cnt) begin
                    rd_en  = 1'b1;
                    n_ptr  = r_ptr + CW'(1);
                    n_dv   = 1'b1;
                    n_didx = r_ptr[AW-1:0];
                end
                if (r_dv) begin
                    wr_en   = 1'b1;
                    wr_lidx = CW'(r_didx) - CW'(1);
                    wr_data = rd_slot;
                end else if (!(r_ptr < r_cnt)) begin
                    n_cnt = cnt_dec;
                    if (r_req.op == saq_pkg::OP_ADD) begin
                        n_ptr   = cnt_dec;
                        n_state = saq_pkg::ST_INSERT;
                    end else begin
                        n_state = saq_pkg::ST_RESP;
                    end
                end
            end

            saq_pkg::ST_INSERT: begin
                if (r_ptr != '0) begin
                    rd_en   = 1'b1;
                    rd_lidx = ptr_dec;
                    n_ptr   = ptr_dec;
                    n_dv    = 1'b1;
                    n_didx  = ptr_dec[AW-1:0];
                end
                if (r_dv) begin
                    wr_en   = 1'b1;
                    wr_lidx = CW'(r_didx) + CW'(1);
                    if (r_req.alarm_time <= rd_slot.alarm_time) begin
                        wr_data = rd_slot;
                    end else begin
                        wr_data = new_slot;
                        n_dv    = 1'b0;
                        n_cnt   = r_cnt + CW'(1);
                        n_state = saq_pkg::ST_RESP;
                    end
                end else if (r_ptr == '0) begin
                    wr_en   = 1'b1;
                    wr_lidx = '0;
                    wr_data = new_slot;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = saq_pkg::ST_RESP;
                end
            end

            saq_pkg::ST_EXP_CHECK: begin
                if ((r_cnt != '0) && (r_head.alarm_time <= r_req.current_time)) begin
                    rd_en   = 1'b1;
                    rd_lidx = CW'(1);
                    n_state = saq_pkg::ST_EXP_POP;
                end else begin
                    n_state = saq_pkg::ST_RESP;
                end
            end

            saq_pkg::ST_EXP_POP: begin
                if (out_free) begin
                    out_load                 = 1'b1;
                    out_data.kind            = saq_pkg::KIND_FIRED;
                    out_data.status          = saq_pkg::STATUS_OK;
                    out_data.fired_id        = r_head.alarm_id;
                    out_data.last            = !nxt_due;
                    out_data.armed           = more;
                    out_data.next_alarm_time = more ? rd_slot.alarm_time : '0;
                    if (more) begin
                        n_head = rd_slot;
                    end
                    n_base  = f_phys(r_base, CW'(1));
                    n_cnt   = cnt_dec;
                    n_n     = r_n + NW'(1);
                    n_state = nxt_due ? saq_pkg::ST_EXP_CHECK : saq_pkg::ST_IDLE;
                end
            end

            saq_pkg::ST_RESP: begin
                if (out_free) begin
                    out_load                 = 1'b1;
                    out_data.kind            = saq_pkg::KIND_ACK;
                    out_data.status          = r_status;
                    out_data.fired_id        = '0;
                    out_data.last            = 1'b1;
                    out_data.armed           = (r_cnt != '0);
                    out_data.next_alarm_time = (r_cnt != '0) ? r_head.alarm_time : '0;
                    n_state                  = saq_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = saq_pkg::ST_IDLE;
            end
        endcase

        if (wr_en && (wr_lidx == '0)) begin
            n_head = wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= saq_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_base      <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_base  <= n_base;
            r_dv    <= n_dv;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_head   <= n_head;
        r_ptr    <= n_ptr;
        r_didx   <= n_didx;
        r_status <= n_status;
        r_n      <= n_n;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(Depth))
        else $error("pending count beyond queue depth");

    a_fire_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (out_data.kind == saq_pkg::KIND_FIRED))
            |=> (r_cnt == ($past(r_cnt) - CW'(1))))
        else $error("fired response without head pop");

    a_armed_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out.armed == (r_cnt != '0)))
        else $error("armed flag disagrees with pending count");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == saq_pkg::ST_IDLE) |-> !wr_en)
        else $error("slot write while idle");

endmodule

`default_nettype wire

// File: verif/sorted_alarm_queue_top_test.sv
// ============================================================================
// sorted_alarm_queue_top_test
// Self-checking bench for the sorted alarm queue: requests from a queue are
// driven under four traffic phases, every response is checked field by field
// against a sorted-table predictor updated as each request is accepted.
// ============================================================================

module sorted_alarm_queue_top_test;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         TOTAL_ITEMS   = 410;
    localparam int         QUIET_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES  = 80;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    saq_pkg::t_in_req  i_in_req    = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    saq_pkg::t_out_rsp o_out_rsp;

    sorted_alarm_queue_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    saq_pkg::t_in_req  pending_reqs[$];
    saq_pkg::t_out_rsp awaited_rsps[$];
    logic [31:0] alarm_times[saq_pkg::QUEUE_DEPTH];
    logic [3:0]  alarm_ids[saq_pkg::QUEUE_DEPTH];
    int          alarm_count    = 0;
    int          queued_reqs    = 0;
    int          accepted_reqs  = 0;
    int          checked_rsps   = 0;
    int          fired_rsps     = 0;
    int          fail_count     = 0;
    int          quiet_cycles   = 0;
    int          send_idle_pct  = 0;
    int          rsp_stall_pct  = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void queue_req(logic [1:0] op, logic [3:0] id, logic [31:0] at,
                                      logic [31:0] now);
        saq_pkg::t_in_req req;
        req.op           = op;
        req.alarm_id     = id;
        req.alarm_time   = at;
        req.current_time = now;
        pending_reqs.push_back(req);
        queued_reqs++;
    endfunction

    function automatic int find_alarm(logic [3:0] id);
        for (int i = 0; i < alarm_count; i++) begin
            if (alarm_ids[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic void remove_alarm(int pos);
        for (int i = pos; i + 1 < alarm_count; i++) begin
            alarm_times[i] = alarm_times[i + 1];
            alarm_ids[i]   = alarm_ids[i + 1];
        end
        alarm_count--;
    endfunction

    function automatic void await_rsp(logic kind, logic [1:0] status, logic [3:0] id,
                                      logic last);
        saq_pkg::t_out_rsp rsp;
        rsp.kind            = kind;
        rsp.status          = status;
        rsp.fired_id        = id;
        rsp.last            = last;
        rsp.armed           = (alarm_count > 0);
        rsp.next_alarm_time = (alarm_count > 0) ? alarm_times[0] : '0;
        awaited_rsps.push_back(rsp);
    endfunction

    function automatic void apply_alarm_request(saq_pkg::t_in_req req);
        int         pos;
        int         ins;
        int         fired;
        logic [3:0] fid;
        logic       more;
        case (req.op)
            saq_pkg::OP_ADD: begin
                pos = find_alarm(req.alarm_id);
                if (pos >= 0) remove_alarm(pos);
                if (alarm_count >= saq_pkg::QUEUE_DEPTH) begin
                    await_rsp(saq_pkg::KIND_ACK, saq_pkg::STATUS_FULL, 4'd0, 1'b1);
                end else begin
                    ins = 0;
                    while (ins < alarm_count && req.alarm_time > alarm_times[ins]) ins++;
                    for (int i = alarm_count; i > ins; i--) begin
                        alarm_times[i] = alarm_times[i - 1];
                        alarm_ids[i]   = alarm_ids[i - 1];
                    end
                    alarm_times[ins] = req.alarm_time;
                    alarm_ids[ins]   = req.alarm_id;
                    alarm_count++;
                    await_rsp(saq_pkg::KIND_ACK, saq_pkg::STATUS_OK, 4'd0, 1'b1);
                end
            end
            saq_pkg::OP_CANCEL: begin
                pos = find_alarm(req.alarm_id);
                if (pos >= 0) begin
                    remove_alarm(pos);
                    await_rsp(saq_pkg::KIND_ACK, saq_pkg::STATUS_OK, 4'd0, 1'b1);
                end else begin
                    await_rsp(saq_pkg::KIND_ACK, saq_pkg::STATUS_NOT_FOUND, 4'd0, 1'b1);
                end
            end
            saq_pkg::OP_EXPIRE: begin
                fired = 0;
                more  = (alarm_count > 0) && (alarm_times[0] <= req.current_time);
                while (more) begin
                    fid = alarm_ids[0];
                    remove_alarm(0);
                    fired++;
                    more = (fired < saq_pkg::MAX_RESULTS) && (alarm_count > 0) &&
                           (alarm_times[0] <= req.current_time);
                    await_rsp(saq_pkg::KIND_FIRED, saq_pkg::STATUS_OK, fid, !more);
                end
                if (fired == 0) await_rsp(saq_pkg::KIND_ACK, saq_pkg::STATUS_OK, 4'd0, 1'b1);
            end
            default: begin
                await_rsp(saq_pkg::KIND_ACK, saq_pkg::STATUS_OK, 4'd0, 1'b1);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR response %0d: %s got 0x%0h expected 0x%0h",
                 checked_rsps, what, got, want);
        fail_count++;
    endtask

    task automatic check_rsp(saq_pkg::t_out_rsp got);
        saq_pkg::t_out_rsp want;
        if (awaited_rsps.size() == 0) begin
            report_mismatch("response with none awaited, fired_id", 32'(got.fired_id),
                            32'd0);
            return;
        end
        want = awaited_rsps.pop_front();
        if (got.kind !== want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.fired_id !== want.fired_id)
            report_mismatch("fired_id", 32'(got.fired_id), 32'(want.fired_id));
        if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
        if (got.armed !== want.armed)
            report_mismatch("armed", 32'(got.armed), 32'(want.armed));
        if (got.next_alarm_time !== want.next_alarm_time)
            report_mismatch("next_alarm_time", got.next_alarm_time, want.next_alarm_time);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_req   <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    // monitor: predict on request, check on response
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                apply_alarm_request(i_in_req);
                accepted_reqs++;
            end
            if (o_out_valid && !i_out_stall) begin
                check_rsp(o_out_rsp);
                if (o_out_rsp.kind == saq_pkg::KIND_FIRED) fired_rsps++;
                checked_rsps++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     quiet_cycles, awaited_rsps.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          pick;
        int          burst;
        logic [31:0] time_base;
        time_base = $urandom;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1:       begin send_idle_pct = 66; rsp_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  rsp_stall_pct = 66; end
                default: begin send_idle_pct = 18; rsp_stall_pct = 18; end
            endcase
            if (ph == 0) begin
                queue_req(saq_pkg::OP_EXPIRE, 4'd0, 32'd0, 32'd0);
                queue_req(saq_pkg::OP_CANCEL, 4'd5, 32'd0, 32'd0);
                queue_req(OP_UNUSED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                queue_req(saq_pkg::OP_ADD, 4'd0, 32'hFFFF_FFFF, 32'd0);
                queue_req(saq_pkg::OP_ADD, 4'd15, 32'd0, 32'd0);
                queue_req(saq_pkg::OP_ADD, 4'd7, 32'd100, 32'd0);
                queue_req(saq_pkg::OP_ADD, 4'd8, 32'd100, 32'd0);
                queue_req(saq_pkg::OP_ADD, 4'd7, 32'd50, 32'd0);
                queue_req(saq_pkg::OP_CANCEL, 4'd15, 32'd0, 32'd0);
                queue_req(saq_pkg::OP_EXPIRE, 4'd0, 32'd0, 32'd99);
                for (int id = 1; id < 16; id++) begin
                    if (id != 8) queue_req(saq_pkg::OP_ADD, id[3:0],
                                           32'h8000_0000 + 32'(id % 4), 32'd0);
                end
                queue_req(saq_pkg::OP_ADD, 4'd3, 32'h7FFF_FFFF, 32'd0);
                queue_req(saq_pkg::OP_EXPIRE, 4'd0, 32'd0, 32'hFFFF_FFFF);
            end
            while (queued_reqs < (ph + 1) * TOTAL_ITEMS / 4) begin
                pick = $urandom_range(9);
                if (pick < 4) begin
                    burst = $urandom_range(8, 1);
                    repeat (burst) begin
                        queue_req(saq_pkg::OP_ADD, 4'($urandom_range(15)),
                                  ($urandom_range(7) == 0) ? $urandom
                                                           : time_base + $urandom_range(40),
                                  $urandom);
                    end
                end else if (pick < 6) begin
                    burst = $urandom_range(3, 1);
                    repeat (burst) queue_req(saq_pkg::OP_CANCEL, 4'($urandom_range(15)),
                                             $urandom, $urandom);
                end else if (pick < 9) begin
                    time_base = time_base + $urandom_range(12);
                    case ($urandom_range(9))
                        0:       queue_req(saq_pkg::OP_EXPIRE, 4'($urandom), $urandom,
                                           32'hFFFF_FFFF);
                        1:       queue_req(saq_pkg::OP_EXPIRE, 4'($urandom), $urandom,
                                           $urandom);
                        default: queue_req(saq_pkg::OP_EXPIRE, 4'($urandom), $urandom,
                                           time_base + $urandom_range(30));
                    endcase
                end else begin
                    queue_req(2'($urandom_range(3)), 4'($urandom), $urandom, $urandom);
                end
            end
            while (pending_reqs.size() > 0 || i_in_valid || awaited_rsps.size() > 0)
                @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Accepted %0d requests over four traffic phases; checked %0d responses,",
                 accepted_reqs, checked_rsps);
        $display("%0d of them fired alarms; %0d mismatches", fired_rsps, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sorted_alarm_queue_top.f
hdl/saq_pkg.sv
hdl/saq_ram.sv
hdl/sorted_alarm_queue_top.sv
verif/sorted_alarm_queue_top_test.sv
